// ===== sv/rc4_pkg.sv =====
// rc4_pkg: shared constants and types for the RC4 cipher block.
// No dependencies.

package rc4_pkg;

   localparam int STATE_SIZE    = 256;
   localparam int MAX_KEY_BYTES = 256;
   localparam int BYTE_W        = 8;
   localparam int IDX_W         = $clog2(STATE_SIZE);
   localparam int KEY_ADDR_W    = $clog2(MAX_KEY_BYTES);
   localparam int KEY_LEN_W     = KEY_ADDR_W + 1;

   localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(STATE_SIZE - 1);
   localparam logic [KEY_LEN_W-1:0] KEY_FULL = KEY_LEN_W'(MAX_KEY_BYTES);

   localparam logic ACTION_LOAD_KEY = 1'b0;
   localparam logic ACTION_DATA     = 1'b1;

   typedef enum logic [3:0] {
      ST_FILL,
      ST_IDLE,
      ST_KS_RD,
      ST_KS_ACC,
      ST_KS_WK,
      ST_KS_WA,
      ST_DT_RJ,
      ST_DT_WI,
      ST_DT_WJ
   } state_type;

endpackage

// ===== sv/rc4_ram.sv =====
// rc4_ram: generic single write port, single read port RAM, registered read.
// No dependencies.

module rc4_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/rc4_seq.sv =====
// rc4_seq: sequencer, shared 8-bit adder, indices and result register.
// Depends on rc4_pkg; drives the permutation and key RAMs.

module rc4_seq import rc4_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [BYTE_W-1:0]     req_byte_value,
   input  logic                  req_key_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_W-1:0]     rsp_cipher_byte,
   output logic [BYTE_W-1:0]     rsp_keystream_byte,
   output logic                  perm_we,
   output logic [IDX_W-1:0]      perm_waddr,
   output logic [BYTE_W-1:0]     perm_wdata,
   output logic [IDX_W-1:0]      perm_raddr,
   input  logic [BYTE_W-1:0]     perm_rdata,
   output logic                  key_we,
   output logic [KEY_ADDR_W-1:0] key_waddr,
   output logic [BYTE_W-1:0]     key_wdata,
   output logic [KEY_ADDR_W-1:0] key_raddr,
   input  logic [BYTE_W-1:0]     key_rdata
);

   state_type             state_ff, state_in;
   logic                  sched_ff, sched_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W-1:0]      i_ff, i_in;
   logic [IDX_W-1:0]      j_ff, j_in;
   logic [IDX_W-1:0]      t_ff, t_in;
   logic [KEY_LEN_W-1:0]  klen_ff, klen_in;
   logic [KEY_ADDR_W-1:0] kidx_ff, kidx_in;
   logic [BYTE_W-1:0]     si_ff, si_in;
   logic [BYTE_W-1:0]     sj_ff, sj_in;
   logic [BYTE_W-1:0]     byte_ff, byte_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     cipher_ff, cipher_in;
   logic [BYTE_W-1:0]     ks_ff, ks_in;

   logic [BYTE_W-1:0]     add_a, add_b, add_c, add_sum;
   logic                  accept, out_free;
   logic [BYTE_W-1:0]     kb, ks_word;
   logic [KEY_LEN_W-1:0]  kidx_next;

   // shared adder, modulo 256
   assign add_sum = add_a + add_b + add_c;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign kb        = (klen_ff == '0) ? '0 : key_rdata;
   assign kidx_next = {1'b0, kidx_ff} + KEY_LEN_W'(1);

   // keystream word after the swap: forward the freshly swapped entries
   always_comb begin
      if (t_ff == i_ff) begin
         ks_word = sj_ff;
      end else if (t_ff == j_ff) begin
         ks_word = si_ff;
      end else begin
         ks_word = perm_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         sched_ff     <= 1'b0;
         cnt_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         klen_ff      <= '0;
         kidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sched_ff     <= sched_in;
         cnt_ff       <= cnt_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         klen_ff      <= klen_in;
         kidx_ff      <= kidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff      <= t_in;
      si_ff     <= si_in;
      sj_ff     <= sj_in;
      byte_ff   <= byte_in;
      cipher_ff <= cipher_in;
      ks_ff     <= ks_in;
   end

   always_comb begin
      state_in     = state_ff;
      sched_in     = sched_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      t_in         = t_ff;
      klen_in      = klen_ff;
      kidx_in      = kidx_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      byte_in      = byte_ff;
      cipher_in    = cipher_ff;
      ks_in        = ks_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      add_a = i_ff;
      add_b = '0;
      add_c = '0;

      req_stall  = (state_ff != ST_IDLE);
      perm_we    = 1'b0;
      perm_waddr = cnt_ff;
      perm_wdata = cnt_ff;
      perm_raddr = cnt_ff;
      key_we     = 1'b0;
      key_waddr  = klen_ff[KEY_ADDR_W-1:0];
      key_wdata  = req_byte_value;
      key_raddr  = kidx_ff;

      case (state_ff)
         ST_FILL: begin
            perm_we = 1'b1;
            cnt_in  = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_IDX) begin
               j_in    = '0;
               kidx_in = '0;
               state_in = sched_ff ? ST_KS_RD : ST_IDLE;
            end
         end
         ST_IDLE: begin
            add_a = i_ff;
            add_b = BYTE_W'(1);
            perm_raddr = add_sum;
            if (accept) begin
               if (req_action == ACTION_LOAD_KEY) begin
                  if (klen_ff != KEY_FULL) begin
                     key_we  = 1'b1;
                     klen_in = klen_ff + KEY_LEN_W'(1);
                  end
                  if (req_key_last) begin
                     sched_in = 1'b1;
                     cnt_in   = '0;
                     state_in = ST_FILL;
                  end
               end else begin
                  i_in     = add_sum;
                  byte_in  = req_byte_value;
                  state_in = ST_DT_RJ;
               end
            end
         end
         ST_KS_RD: begin
            state_in = ST_KS_ACC;
         end
         ST_KS_ACC: begin
            add_a = j_ff;
            add_b = perm_rdata;
            add_c = kb;
            perm_raddr = add_sum;
            si_in = perm_rdata;
            j_in  = add_sum;
            kidx_in = (kidx_next == klen_ff) ? '0 : kidx_next[KEY_ADDR_W-1:0];
            state_in = ST_KS_WK;
         end
         ST_KS_WK: begin
            perm_we    = 1'b1;
            perm_waddr = cnt_ff;
            perm_wdata = perm_rdata;
            state_in   = ST_KS_WA;
         end
         ST_KS_WA: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            cnt_in     = cnt_ff + IDX_W'(1);
            if (cnt_ff == LAST_IDX) begin
               i_in     = '0;
               j_in     = '0;
               klen_in  = '0;
               sched_in = 1'b0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KS_RD;
            end
         end
         ST_DT_RJ: begin
            add_a = j_ff;
            add_b = perm_rdata;
            perm_raddr = add_sum;
            si_in = perm_rdata;
            j_in  = add_sum;
            state_in = ST_DT_WI;
         end
         ST_DT_WI: begin
            add_a = si_ff;
            add_b = perm_rdata;
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = perm_rdata;
            perm_raddr = add_sum;
            sj_in = perm_rdata;
            t_in  = add_sum;
            state_in = ST_DT_WJ;
         end
         ST_DT_WJ: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            perm_raddr = t_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               ks_in        = ks_word;
               cipher_in    = byte_ff ^ ks_word;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cipher_byte    = cipher_ff;
   assign rsp_keystream_byte = ks_ff;

endmodule

// ===== sv/rc4_stream_cipher_top.sv =====
// RC4 stream cipher top level: permutation RAM, key RAM and sequencer.
// Depends on rc4_pkg, rc4_ram and rc4_seq.
// Data beat: ST_DT_RJ, ST_DT_WI, ST_DT_WJ; result registered in ST_DT_WJ, held there
// by a result stall; no new beat before ST_IDLE, as the single permutation RAM port
// serves three reads and a two-write swap. Key beat: stored in ST_IDLE; last key
// beat: identity fill plus schedule. Reset: synchronous; then identity fill, req_stall high.

module rc4_stream_cipher_top import rc4_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [BYTE_W-1:0] req_byte_value,
   input  logic              req_key_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_cipher_byte,
   output logic [BYTE_W-1:0] rsp_keystream_byte
);

   logic                  perm_we;
   logic [IDX_W-1:0]      perm_waddr;
   logic [BYTE_W-1:0]     perm_wdata;
   logic [IDX_W-1:0]      perm_raddr;
   logic [BYTE_W-1:0]     perm_rdata;
   logic                  key_we;
   logic [KEY_ADDR_W-1:0] key_waddr;
   logic [BYTE_W-1:0]     key_wdata;
   logic [KEY_ADDR_W-1:0] key_raddr;
   logic [BYTE_W-1:0]     key_rdata;

   rc4_ram #(.ADDR_W(IDX_W), .DATA_W(BYTE_W)) u_perm_ram (
      .clock (clock),
      .we    (perm_we),
      .waddr (perm_waddr),
      .wdata (perm_wdata),
      .raddr (perm_raddr),
      .rdata (perm_rdata)
   );

   rc4_ram #(.ADDR_W(KEY_ADDR_W), .DATA_W(BYTE_W)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (key_wdata),
      .raddr (key_raddr),
      .rdata (key_rdata)
   );

   rc4_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_byte_value     (req_byte_value),
      .req_key_last       (req_key_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cipher_byte    (rsp_cipher_byte),
      .rsp_keystream_byte (rsp_keystream_byte),
      .perm_we            (perm_we),
      .perm_waddr         (perm_waddr),
      .perm_wdata         (perm_wdata),
      .perm_raddr         (perm_raddr),
      .perm_rdata         (perm_rdata),
      .key_we             (key_we),
      .key_waddr          (key_waddr),
      .key_wdata          (key_wdata),
      .key_raddr          (key_raddr),
      .key_rdata          (key_rdata)
   );

endmodule

// ===== verif/tb_rc4_stream_cipher_top.sv =====
// Testbench for rc4_stream_cipher_top: directed table, then random key/data traffic,
// every data beat checked against a behavioural RC4 keystream model held here.
// Depends on rc4_pkg and the RTL of rc4_stream_cipher_top.

module tb_rc4_stream_cipher_top import rc4_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCRIPT_LEN     = 24;
   localparam int RANDOM_BEATS   = 600;
   localparam int QUIET_FROM     = 540;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int TAIL_CYCLES    = 20;

   typedef struct packed {
      logic              action;
      logic [BYTE_W-1:0] value;
      logic              key_last;
      logic              typed;
      logic [BYTE_W-1:0] want_cipher;
      logic [BYTE_W-1:0] want_ks;
   } script_row_type;

   typedef struct packed {
      logic [BYTE_W-1:0] cipher;
      logic [BYTE_W-1:0] ks;
   } cipher_beat_type;

   logic              clock;
   logic              reset              = 1'b1;
   logic              req_valid          = 1'b0;
   logic              req_stall;
   logic              req_action         = ACTION_LOAD_KEY;
   logic [BYTE_W-1:0] req_byte_value     = '0;
   logic              req_key_last       = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall          = 1'b0;
   logic [BYTE_W-1:0] rsp_cipher_byte;
   logic [BYTE_W-1:0] rsp_keystream_byte;

   // predictor state
   logic [BYTE_W-1:0]    sbox    [STATE_SIZE];
   logic [BYTE_W-1:0]    key_mem [MAX_KEY_BYTES];
   logic [KEY_LEN_W-1:0] key_count;
   logic [IDX_W-1:0]     gen_i;
   logic [IDX_W-1:0]     gen_j;

   cipher_beat_type cipher_due[$];
   cipher_beat_type got_want;

   bit          idle_en = 1'b1;
   int unsigned stall_left   = 0;
   int unsigned idle_cycles  = 0;
   int unsigned mismatches   = 0;
   int unsigned key_beats    = 0;
   int unsigned data_beats   = 0;
   int unsigned schedules    = 0;
   int unsigned beats_seen   = 0;

   // the first three rows run on the reset permutation: keystream 2, 5, 7
   script_row_type script [SCRIPT_LEN] = '{
      '{ACTION_DATA,     8'h00, 1'b0, 1'b1, 8'h02, 8'h02},
      '{ACTION_DATA,     8'hFF, 1'b0, 1'b1, 8'hFA, 8'h05},
      '{ACTION_DATA,     8'h80, 1'b1, 1'b1, 8'h87, 8'h07},
      '{ACTION_LOAD_KEY, 8'h00, 1'b1, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_LOAD_KEY, 8'hFF, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_LOAD_KEY, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_LOAD_KEY, 8'hFF, 1'b1, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'h55, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'hAA, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'hFF, 1'b1, 1'b0, 8'h00, 8'h00},
      '{ACTION_LOAD_KEY, 8'h4B, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_LOAD_KEY, 8'h65, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_LOAD_KEY, 8'h79, 1'b1, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'h50, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'h6C, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'h61, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'h69, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'h6E, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'h74, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'h65, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'h78, 1'b0, 1'b0, 8'h00, 8'h00},
      '{ACTION_DATA,     8'h74, 1'b0, 1'b0, 8'h00, 8'h00}
   };

   rc4_stream_cipher_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_byte_value     (req_byte_value),
      .req_key_last       (req_key_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cipher_byte    (rsp_cipher_byte),
      .rsp_keystream_byte (rsp_keystream_byte)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic void run_key_schedule();
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] kb;
      logic [BYTE_W-1:0] t;
      acc = '0;
      for (int k = 0; k < STATE_SIZE; k++) sbox[k] = BYTE_W'(k);
      for (int k = 0; k < STATE_SIZE; k++) begin
         kb  = (key_count == 0) ? '0 : key_mem[k % int'(key_count)];
         acc = BYTE_W'(acc + sbox[k] + kb);
         t         = sbox[k];
         sbox[k]   = sbox[acc];
         sbox[acc] = t;
      end
      gen_i     = '0;
      gen_j     = '0;
      key_count = '0;
      schedules++;
   endfunction

   function automatic void absorb_key_byte(logic [BYTE_W-1:0] v, logic last);
      if (key_count < KEY_FULL) begin
         key_mem[key_count[KEY_ADDR_W-1:0]] = v;
         key_count++;
      end
      if (last) run_key_schedule();
   endfunction

   function automatic logic [BYTE_W-1:0] next_keystream_byte();
      logic [BYTE_W-1:0] t;
      gen_i       = gen_i + 1'b1;
      gen_j       = IDX_W'(gen_j + sbox[gen_i]);
      t           = sbox[gen_i];
      sbox[gen_i] = sbox[gen_j];
      sbox[gen_j] = t;
      return sbox[IDX_W'(sbox[gen_i] + sbox[gen_j])];
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [BYTE_W-1:0] got,
                                  logic [BYTE_W-1:0] want);
      $display("MISMATCH at %0t: %s got %02h want %02h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic send_beat(logic act, logic [BYTE_W-1:0] val, logic last,
                            logic typed = 1'b0, logic [BYTE_W-1:0] want_cipher = '0,
                            logic [BYTE_W-1:0] want_ks = '0);
      logic [BYTE_W-1:0] ks;
      cipher_beat_type   due;
      if (idle_en && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_byte_value <= val;
      req_key_last   <= last;
      do @(posedge clock); while (req_stall);
      if (act == ACTION_DATA) begin
         ks = next_keystream_byte();
         if (typed) begin
            due.cipher = want_cipher;
            due.ks     = want_ks;
         end else begin
            due.cipher = val ^ ks;
            due.ks     = ks;
         end
         cipher_due = {cipher_due, due};
         data_beats++;
      end else begin
         absorb_key_byte(val, last);
         key_beats++;
      end
   endtask

   // result side: stall bursts while idling is on
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (cipher_due.size() == 0) begin
            report_mismatch("unexpected result, cipher", rsp_cipher_byte, 8'h00);
         end else begin
            got_want = cipher_due.pop_front();
            if (rsp_cipher_byte !== got_want.cipher)
               report_mismatch("cipher_byte", rsp_cipher_byte, got_want.cipher);
            if (rsp_keystream_byte !== got_want.ks)
               report_mismatch("keystream_byte", rsp_keystream_byte, got_want.ks);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int unsigned counted;
      int unsigned group;
      int unsigned len;
      int unsigned n;
      int unsigned pick;
      counted = 0;
      group   = 0;
      for (int k = 0; k < STATE_SIZE; k++) sbox[k] = BYTE_W'(k);
      key_count = '0;
      gen_i     = '0;
      gen_j     = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < SCRIPT_LEN; r++)
         send_beat(script[r].action, script[r].value, script[r].key_last,
                   script[r].typed, script[r].want_cipher, script[r].want_ks);

      while (counted < RANDOM_BEATS) begin
         idle_en = (counted < QUIET_FROM) && ($urandom_range(0, 3) != 0);
         pick    = $urandom_range(0, 99);
         if (group == 2 || group == 6) begin
            // long key: group 2 overfills the store, dropping bytes incl. the last-marked one
            len = (group == 2) ? $urandom_range(257, 262) : $urandom_range(250, 256);
            for (int k = 0; k < len; k++)
               send_beat(ACTION_LOAD_KEY, pick_byte(), k == len - 1);
            n = $urandom_range(4, 20);
            for (int k = 0; k < n; k++) send_beat(ACTION_DATA, pick_byte(), 1'b0);
            counted += len + n;
         end else if (pick < 10) begin
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
               send_beat(1'($urandom_range(0, 1)), pick_byte(), 1'($urandom_range(0, 1)));
            counted += n;
         end else if (pick < 25) begin
            // partial key, data runs on the old schedule, next key continues it
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) send_beat(ACTION_LOAD_KEY, pick_byte(), 1'b0);
            n = $urandom_range(1, 10);
            for (int k = 0; k < n; k++) send_beat(ACTION_DATA, pick_byte(), 1'b0);
            counted += len + n;
         end else begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            for (int k = 0; k < len; k++)
               send_beat(ACTION_LOAD_KEY, pick_byte(), k == len - 1);
            n = $urandom_range(1, 40);
            for (int k = 0; k < n; k++)
               send_beat(ACTION_DATA, pick_byte(), $urandom_range(0, 9) == 0);
            counted += len + n;
         end
         group++;
      end
      req_valid <= 1'b0;

      while (cipher_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run: %0d key beats, %0d data beats, %0d key schedules, %0d results checked",
               key_beats, data_beats, schedules, beats_seen);
      $display("run: %0d random groups incl. overlong keys and data before any key",
               group);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== rc4_stream_cipher_top.f =====
sv/rc4_pkg.sv
sv/rc4_ram.sv
sv/rc4_seq.sv
sv/rc4_stream_cipher_top.sv
verif/tb_rc4_stream_cipher_top.sv
